[sv/bcf_pkg.sv]
// bcf_pkg: shared widths, field offsets and controller/datapath interface structs
// for the bilinear cell row fill block. Depends on nothing; every bcf_* file uses it.
package bcf_pkg;

  // fixed point and size limits
  localparam int FRAC_BITS = 6;
  localparam int MAX_W     = 64;
  localparam int MAX_H     = 1024;

  // input field widths
  localparam int CORNER_W = 14;
  localparam int WIDTH_W  = 7;
  localparam int HEIGHT_W = 11;
  localparam int ROW_W    = 10;

  // result field widths
  localparam int COLOR_W = 8;
  localparam int COL_W   = $clog2(MAX_W);

  // internal widths
  localparam int HM1_W  = $clog2(MAX_H);        // height minus one
  localparam int NUM_W  = ROW_W + CORNER_W;     // row * |diff| + half
  localparam int STEP_W = COL_W;                // Bresenham step and error
  localparam int Y_W    = CORNER_W + 2;         // signed running value
  localparam int HALF_Y = 1 << (FRAC_BITS - 1);

  // divider: two quotient bits per cycle
  localparam int DIV_RADIX = 2;
  localparam int DIV_CYC   = NUM_W / DIV_RADIX;
  localparam int DIV_CNT_W = $clog2(DIV_CYC);

  // input tdata layout, lowest field first
  localparam int UL_LSB  = 0;
  localparam int UR_LSB  = UL_LSB + CORNER_W;
  localparam int LL_LSB  = UR_LSB + CORNER_W;
  localparam int LR_LSB  = LL_LSB + CORNER_W;
  localparam int W_LSB   = LR_LSB + CORNER_W;
  localparam int H_LSB   = W_LSB + WIDTH_W;
  localparam int ROW_LSB = H_LSB + HEIGHT_W;
  localparam int IN_BITS = ROW_LSB + ROW_W;
  localparam int IN_W    = ((IN_BITS + 7) / 8) * 8;

  // output tdata layout
  localparam int OUT_BITS = COLOR_W + COL_W;
  localparam int OUT_W    = ((OUT_BITS + 7) / 8) * 8;

  // controller -> datapath
  typedef struct packed {
    logic load;        // capture input beat
    logic prep;        // form numerators
    logic start_side;  // start both side divisions
    logic setup;       // row ends, slope, walk start values
    logic start_step;  // start |dy| / step division
    logic walk_init;   // capture slope quotient and remainder
    logic emit;        // load one pixel into the output register
  } cmd_t;

  // datapath -> controller
  typedef struct packed {
    logic empty;       // item yields no pixels
    logic div_done;
    logic div_busy;
    logic out_space;   // output register free this cycle
    logic last_col;    // current pixel is the last of the row
  } sts_t;

endpackage

[sv/bcf_div.sv]
// bcf_div: iterative unsigned restoring divider, two quotient bits per cycle.
// Depends on bcf_pkg for operand widths.
module bcf_div (
  input  logic                      clk,
  input  logic                      rst_n,
  input  logic                      start,
  input  logic [bcf_pkg::NUM_W-1:0] dividend,
  input  logic [bcf_pkg::HM1_W-1:0] divisor,
  output logic [bcf_pkg::NUM_W-1:0] quotient,
  output logic [bcf_pkg::HM1_W-1:0] remainder,
  output logic                      busy,
  output logic                      done
);

  logic [bcf_pkg::NUM_W-1:0]     quo_r, quo_nxt;
  logic [bcf_pkg::HM1_W-1:0]     rem_r, rem_nxt;
  logic [bcf_pkg::HM1_W-1:0]     dvs_r;
  logic [bcf_pkg::DIV_CNT_W-1:0] cnt_r;
  logic                          busy_r, done_r;

  always_comb begin
    logic [bcf_pkg::HM1_W:0] part;
    logic                    qbit;
    rem_nxt = rem_r;
    quo_nxt = quo_r;
    for (int i = 0; i < bcf_pkg::DIV_RADIX; i++) begin
      part = {rem_nxt, quo_nxt[bcf_pkg::NUM_W-1]};
      qbit = 1'b0;
      if (part >= {1'b0, dvs_r}) begin
        part = part - {1'b0, dvs_r};
        qbit = 1'b1;
      end
      rem_nxt = part[bcf_pkg::HM1_W-1:0];
      quo_nxt = {quo_nxt[bcf_pkg::NUM_W-2:0], qbit};
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      done_r <= 1'b0;
      cnt_r  <= '0;
    end else begin
      done_r <= 1'b0;
      if (start) begin
        busy_r <= 1'b1;
        cnt_r  <= '0;
      end else if (busy_r) begin
        cnt_r <= cnt_r + 1'b1;
        if (cnt_r == bcf_pkg::DIV_CNT_W'(bcf_pkg::DIV_CYC - 1)) begin
          busy_r <= 1'b0;
          done_r <= 1'b1;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (start) begin
      quo_r <= dividend;
      rem_r <= '0;
      dvs_r <= divisor;
    end else if (busy_r) begin
      quo_r <= quo_nxt;
      rem_r <= rem_nxt;
    end
  end

  assign quotient  = quo_r;
  assign remainder = rem_r;
  assign busy      = busy_r;
  assign done      = done_r;

endmodule

[sv/bcf_dp.sv]
// bcf_dp: datapath of the row fill: input capture, side interpolation through two
// dividers, slope division, Bresenham pixel walk and output register. Uses bcf_pkg, bcf_div.
module bcf_dp (
  input  logic                        clk,
  input  logic                        rst_n,
  input  bcf_pkg::cmd_t               cmd,
  output bcf_pkg::sts_t               sts,
  input  logic [bcf_pkg::IN_W-1:0]    in_data,
  input  logic                        cfg_we,
  input  logic [bcf_pkg::COLOR_W-1:0] cfg_data,
  output logic                        out_valid,
  input  logic                        out_ready,
  output logic [bcf_pkg::OUT_W-1:0]   out_data,
  output logic                        out_last
);

  // captured item
  logic [bcf_pkg::CORNER_W-1:0] ul_r, ur_r, ll_r, lr_r;
  logic [bcf_pkg::WIDTH_W-1:0]  w_r;
  logic [bcf_pkg::HEIGHT_W-1:0] h_r;
  logic [bcf_pkg::ROW_W-1:0]    row_r;
  logic [bcf_pkg::COLOR_W-1:0]  clip_max_r;

  logic [bcf_pkg::WIDTH_W-1:0]  w_in;
  logic [bcf_pkg::HEIGHT_W-1:0] h_in;

  // interpolation
  logic signed [bcf_pkg::CORNER_W:0] dl, dr;
  logic [bcf_pkg::CORNER_W-1:0]      abs_l, abs_r;
  logic [bcf_pkg::HM1_W-1:0]         hm1, half;
  logic [bcf_pkg::NUM_W-1:0]         num_l_r, num_r_r;
  logic                              neg_l_r, neg_r_r, h_one_r;
  logic [bcf_pkg::HM1_W-1:0]         hm1_r;

  // dividers
  logic [bcf_pkg::NUM_W-1:0] div0_a, quo0, quo1;
  logic [bcf_pkg::HM1_W-1:0] div0_b, rem0;
  logic                      busy0, busy1, done0;

  // row ends and slope
  logic [bcf_pkg::CORNER_W:0]        l_sum, r_sum;
  logic [bcf_pkg::CORNER_W-1:0]      lv, rv;
  logic signed [bcf_pkg::CORNER_W:0] dy;
  logic [bcf_pkg::CORNER_W-1:0]      dyabs_r;
  logic                              dneg_r;
  logic [bcf_pkg::STEP_W-1:0]        step_r;

  // walk
  logic signed [bcf_pkg::Y_W-1:0] y_r, y_nxt;
  logic [bcf_pkg::STEP_W-1:0]     e_r, e_nxt;
  logic [bcf_pkg::CORNER_W-1:0]   qd_r;
  logic [bcf_pkg::STEP_W-1:0]     rd_r;
  logic [bcf_pkg::COL_W-1:0]      col_r;
  logic [bcf_pkg::STEP_W:0]       t;
  logic [bcf_pkg::STEP_W+1:0]     ts, e_wide;
  logic [bcf_pkg::CORNER_W:0]     n;
  logic [bcf_pkg::Y_W-bcf_pkg::FRAC_BITS-2:0] ypos;
  logic [bcf_pkg::COLOR_W-1:0]    color;

  // output register
  logic                        out_valid_r;
  logic [bcf_pkg::COLOR_W-1:0] out_color_r;
  logic [bcf_pkg::COL_W-1:0]   out_col_r;
  logic                        out_last_r;

  assign w_in = in_data[bcf_pkg::W_LSB +: bcf_pkg::WIDTH_W];
  assign h_in = in_data[bcf_pkg::H_LSB +: bcf_pkg::HEIGHT_W];

  always_ff @(posedge clk) begin
    if (cmd.load) begin
      ul_r  <= in_data[bcf_pkg::UL_LSB +: bcf_pkg::CORNER_W];
      ur_r  <= in_data[bcf_pkg::UR_LSB +: bcf_pkg::CORNER_W];
      ll_r  <= in_data[bcf_pkg::LL_LSB +: bcf_pkg::CORNER_W];
      lr_r  <= in_data[bcf_pkg::LR_LSB +: bcf_pkg::CORNER_W];
      row_r <= in_data[bcf_pkg::ROW_LSB +: bcf_pkg::ROW_W];
      w_r   <= (w_in > bcf_pkg::WIDTH_W'(bcf_pkg::MAX_W)) ?
               bcf_pkg::WIDTH_W'(bcf_pkg::MAX_W) : w_in;
      h_r   <= (h_in > bcf_pkg::HEIGHT_W'(bcf_pkg::MAX_H)) ?
               bcf_pkg::HEIGHT_W'(bcf_pkg::MAX_H) : h_in;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      clip_max_r <= '1;
    end else if (cfg_we) begin
      clip_max_r <= cfg_data;
    end
  end

  // numerators: row*|diff| + (h-1)/2, sign kept apart
  assign dl    = $signed({1'b0, ll_r}) - $signed({1'b0, ul_r});
  assign dr    = $signed({1'b0, lr_r}) - $signed({1'b0, ur_r});
  assign abs_l = dl[bcf_pkg::CORNER_W] ? bcf_pkg::CORNER_W'(-dl) : dl[bcf_pkg::CORNER_W-1:0];
  assign abs_r = dr[bcf_pkg::CORNER_W] ? bcf_pkg::CORNER_W'(-dr) : dr[bcf_pkg::CORNER_W-1:0];
  assign hm1   = bcf_pkg::HM1_W'(h_r - 1'b1);
  assign half  = hm1 >> 1;

  always_ff @(posedge clk) begin
    if (cmd.prep) begin
      num_l_r <= bcf_pkg::NUM_W'(row_r) * bcf_pkg::NUM_W'(abs_l) + bcf_pkg::NUM_W'(half);
      num_r_r <= bcf_pkg::NUM_W'(row_r) * bcf_pkg::NUM_W'(abs_r) + bcf_pkg::NUM_W'(half);
      neg_l_r <= dl[bcf_pkg::CORNER_W];
      neg_r_r <= dr[bcf_pkg::CORNER_W];
      hm1_r   <= hm1;
      h_one_r <= (h_r == bcf_pkg::HEIGHT_W'(1));
    end
  end

  // divider 0 is shared between the left side and the slope
  assign div0_a = cmd.start_step ? bcf_pkg::NUM_W'(dyabs_r) : num_l_r;
  assign div0_b = cmd.start_step ? bcf_pkg::HM1_W'(step_r) : hm1_r;

  bcf_div u_div0 (
    .clk       (clk),
    .rst_n     (rst_n),
    .start     (cmd.start_side | cmd.start_step),
    .dividend  (div0_a),
    .divisor   (div0_b),
    .quotient  (quo0),
    .remainder (rem0),
    .busy      (busy0),
    .done      (done0)
  );

  bcf_div u_div1 (
    .clk       (clk),
    .rst_n     (rst_n),
    .start     (cmd.start_side),
    .dividend  (num_r_r),
    .divisor   (hm1_r),
    .quotient  (quo1),
    .remainder (),
    .busy      (busy1),
    .done      ()
  );

  // row ends; quotients never exceed the corner difference
  assign l_sum = neg_l_r ? {1'b0, ul_r} - {1'b0, quo0[bcf_pkg::CORNER_W-1:0]}
                         : {1'b0, ul_r} + {1'b0, quo0[bcf_pkg::CORNER_W-1:0]};
  assign r_sum = neg_r_r ? {1'b0, ur_r} - {1'b0, quo1[bcf_pkg::CORNER_W-1:0]}
                         : {1'b0, ur_r} + {1'b0, quo1[bcf_pkg::CORNER_W-1:0]};
  assign lv    = h_one_r ? ul_r : l_sum[bcf_pkg::CORNER_W-1:0];
  assign rv    = h_one_r ? ur_r : r_sum[bcf_pkg::CORNER_W-1:0];
  assign dy    = $signed({1'b0, rv}) - $signed({1'b0, lv});

  // Bresenham step: |dy| = qd*step + rd, so each pixel needs only small adds.
  // err is kept as a magnitude in [0, w-1]; the sign of dy picks the y direction.
  assign t  = {1'b0, e_r} + {1'b0, rd_r};
  assign ts = {1'b0, t} + {2'b0, step_r};

  always_comb begin
    if (t >= w_r) begin
      n      = {1'b0, qd_r} + 1'b1;
      e_wide = {1'b0, t} - {2'b0, step_r};
    end else if (ts >= {1'b0, w_r}) begin
      n      = {1'b0, qd_r};
      e_wide = {1'b0, t};
    end else if (qd_r != '0) begin
      n      = {1'b0, qd_r} - 1'b1;
      e_wide = ts;
    end else begin
      n      = '0;
      e_wide = {1'b0, t};
    end
    e_nxt = e_wide[bcf_pkg::STEP_W-1:0];
    y_nxt = dneg_r ? y_r - $signed(bcf_pkg::Y_W'(n)) : y_r + $signed(bcf_pkg::Y_W'(n));
  end

  // color: drop fraction, negative reads as 0, saturate at clip_max
  assign ypos  = y_r[bcf_pkg::Y_W-1] ? '0 : y_r[bcf_pkg::Y_W-2:bcf_pkg::FRAC_BITS];
  assign color = (ypos > ($bits(ypos))'(clip_max_r)) ? clip_max_r
                                                      : ypos[bcf_pkg::COLOR_W-1:0];

  always_ff @(posedge clk) begin
    if (cmd.setup) begin
      dneg_r  <= dy[bcf_pkg::CORNER_W];
      dyabs_r <= dy[bcf_pkg::CORNER_W] ? bcf_pkg::CORNER_W'(-dy) : dy[bcf_pkg::CORNER_W-1:0];
      y_r     <= bcf_pkg::Y_W'(lv) + bcf_pkg::Y_W'(bcf_pkg::HALF_Y);
      e_r     <= bcf_pkg::STEP_W'((w_r - 1'b1) >> 1);
      step_r  <= (w_r > bcf_pkg::WIDTH_W'(1)) ? bcf_pkg::STEP_W'(w_r - 1'b1)
                                              : bcf_pkg::STEP_W'(1);
    end else if (cmd.emit) begin
      y_r <= y_nxt;
      e_r <= e_nxt;
    end
    if (cmd.walk_init) begin
      qd_r  <= quo0[bcf_pkg::CORNER_W-1:0];
      rd_r  <= rem0[bcf_pkg::STEP_W-1:0];
      col_r <= '0;
    end else if (cmd.emit) begin
      col_r <= col_r + 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (cmd.emit) begin
      out_valid_r <= 1'b1;
    end else if (out_ready) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.emit) begin
      out_color_r <= color;
      out_col_r   <= col_r;
      out_last_r  <= sts.last_col;
    end
  end

  assign out_valid = out_valid_r;
  assign out_data  = bcf_pkg::OUT_W'({out_col_r, out_color_r});
  assign out_last  = out_last_r;

  assign sts.empty     = (w_r == '0) || (h_r == '0) || ({1'b0, row_r} >= h_r);
  assign sts.div_done  = done0;
  assign sts.div_busy  = busy0 | busy1;
  assign sts.out_space = !out_valid_r || out_ready;
  assign sts.last_col  = (col_r == bcf_pkg::COL_W'(w_r - 1'b1));

`ifndef SYNTHESIS
  a_err_range: assert property (@(posedge clk) disable iff (!rst_n)
    cmd.emit |-> ({1'b0, e_r} < w_r))
    else $error("bcf_dp: Bresenham error term out of range");
  a_div_idle: assert property (@(posedge clk) disable iff (!rst_n)
    (cmd.start_side || cmd.start_step) |-> !(busy0 || busy1))
    else $error("bcf_dp: divider restarted while busy");
  a_slope_rem: assert property (@(posedge clk) disable iff (!rst_n)
    cmd.walk_init |-> (rem0 < bcf_pkg::HM1_W'(step_r)))
    else $error("bcf_dp: slope remainder not below step");
`endif

endmodule

[sv/bcf_ctrl.sv]
// bcf_ctrl: sequencer for the row fill: capture, numerators, side division,
// slope division, pixel walk. Uses bcf_pkg command and status structs.
module bcf_ctrl (
  input  logic          clk,
  input  logic          rst_n,
  input  logic          in_valid,
  output logic          in_ready,
  input  bcf_pkg::sts_t sts,
  output bcf_pkg::cmd_t cmd
);

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_PREP,
    ST_SIDE,
    ST_SLOPE,
    ST_PIX
  } state_t;

  state_t state_r, state_nxt;
  logic   start_side_r, start_side_nxt;
  logic   start_step_r, start_step_nxt;

  assign in_ready       = (state_r == ST_IDLE);
  assign cmd.load       = in_valid && (state_r == ST_IDLE);
  assign cmd.prep       = (state_r == ST_PREP) && !sts.empty;
  assign cmd.start_side = start_side_r;
  assign cmd.start_step = start_step_r;
  assign cmd.setup      = (state_r == ST_SIDE) && sts.div_done;
  assign cmd.walk_init  = (state_r == ST_SLOPE) && sts.div_done;
  assign cmd.emit       = (state_r == ST_PIX) && sts.out_space;

  always_comb begin
    state_nxt      = state_r;
    start_side_nxt = 1'b0;
    start_step_nxt = 1'b0;
    case (state_r)
      ST_IDLE: begin
        if (in_valid) state_nxt = ST_PREP;
      end
      ST_PREP: begin
        if (sts.empty) begin
          state_nxt = ST_IDLE;
        end else begin
          state_nxt      = ST_SIDE;
          start_side_nxt = 1'b1;
        end
      end
      ST_SIDE: begin
        if (sts.div_done) begin
          state_nxt      = ST_SLOPE;
          start_step_nxt = 1'b1;
        end
      end
      ST_SLOPE: begin
        if (sts.div_done) state_nxt = ST_PIX;
      end
      ST_PIX: begin
        if (sts.out_space && sts.last_col) state_nxt = ST_IDLE;
      end
      default: begin
        state_nxt = ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r      <= ST_IDLE;
      start_side_r <= 1'b0;
      start_step_r <= 1'b0;
    end else begin
      state_r      <= state_nxt;
      start_side_r <= start_side_nxt;
      start_step_r <= start_step_nxt;
    end
  end

`ifndef SYNTHESIS
  a_last_to_idle: assert property (@(posedge clk) disable iff (!rst_n)
    (cmd.emit && sts.last_col) |=> (state_r == ST_IDLE))
    else $error("bcf_ctrl: row not closed after last pixel");
  a_load_to_prep: assert property (@(posedge clk) disable iff (!rst_n)
    cmd.load |=> (state_r == ST_PREP))
    else $error("bcf_ctrl: accepted beat not processed");
  a_walk_div_idle: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == ST_PIX) |-> !sts.div_busy)
    else $error("bcf_ctrl: divider busy during pixel walk");
`endif

endmodule

[sv/bilinear_cell_row_fill.sv]
// bilinear_cell_row_fill: top level of the bilinear cell row generator.
// Joins bcf_ctrl (sequencer) and bcf_dp (datapath); uses bcf_pkg.
//
// One input beat describes one row of a shaded rectangular cell: four corner
// intensities (color index * 64 + fraction), cell width, cell height and row
// number. The block interpolates the row's left and right values down the
// cell sides (rounded division by height-1, top corners when height is 1),
// then walks across the row with a Bresenham error term and sends one output
// beat per pixel, left to right, with tlast on the last pixel. Every color is
// saturated at clip_max (reset 255). The user must write it through the cfg
// channel while the block is idle; the block does not enforce this. Width is
// clamped to 64 and height to 1024; zero width, zero height or a row at or
// past the height gives no output beats. Sequence: the item is captured, the
// numerators are formed, the two side divisions run in parallel on both
// dividers (a start and then 2 quotient bits per cycle over a 24-bit
// dividend), the row ends are set up, the slope division runs on the first
// divider and the slope quotient is loaded; then the walk sends one pixel per
// cycle while the output is not stalled, width pixels in all. The single
// output register sets the pixel rate; output stalls hold the walk. The next
// beat is taken once the last pixel is in the output register. An item with
// no pixels goes back to idle from the numerator step, starting no divider.
module bilinear_cell_row_fill (
  input  logic                        clk,
  input  logic                        rst_n,
  // upper_left[13:0], upper_right[27:14], lower_left[41:28], lower_right[55:42],
  // cell_width[62:56], cell_height[73:63], row_number[83:74], zero pad
  input  logic [bcf_pkg::IN_W-1:0]    in_tdata,
  input  logic                        in_tvalid,
  output logic                        in_tready,
  // color_index[7:0], column[13:8], zero pad
  output logic [bcf_pkg::OUT_W-1:0]   out_tdata,
  output logic                        out_tlast,
  output logic                        out_tvalid,
  input  logic                        out_tready,
  // clip_max register write
  input  logic [bcf_pkg::COLOR_W-1:0] cfg_data,
  input  logic                        cfg_valid,
  output logic                        cfg_ready
);

  bcf_pkg::cmd_t cmd;
  bcf_pkg::sts_t sts;

  // register write is always taken; software must write only when idle, not enforced here
  assign cfg_ready = 1'b1;

  bcf_ctrl u_ctrl (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_valid (in_tvalid),
    .in_ready (in_tready),
    .sts      (sts),
    .cmd      (cmd)
  );

  bcf_dp u_dp (
    .clk       (clk),
    .rst_n     (rst_n),
    .cmd       (cmd),
    .sts       (sts),
    .in_data   (in_tdata),
    .cfg_we    (cfg_valid),
    .cfg_data  (cfg_data),
    .out_valid (out_tvalid),
    .out_ready (out_tready),
    .out_data  (out_tdata),
    .out_last  (out_tlast)
  );

endmodule
